// ===== src/circle_outline_pixel_generator_macros.svh =====
// assertion macros for the circle outline pixel generator
// used by circle_outline_pixel_generator.sv, no other dependencies
`ifndef CIRCLE_OUTLINE_PIXEL_GENERATOR_MACROS_SVH
`define CIRCLE_OUTLINE_PIXEL_GENERATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define COPG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("copg assertion failed");

// next-cycle implication, disabled while in reset
`define COPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("copg assertion failed");

`endif

// ===== src/copg_pkg.sv =====
// shared types, codes and tables for the circle outline pixel generator
// no dependencies
package copg_pkg;

    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    localparam logic [1:0] CFG_X_LIMIT = 2'd0;
    localparam logic [1:0] CFG_Y_LIMIT = 2'd1;

    localparam logic [15:0] X_LIMIT_RESET = 16'd320;
    localparam logic [15:0] Y_LIMIT_RESET = 16'd240;

    // midpoint decision constants
    localparam logic [11:0] DEC_INIT     = 12'd3;
    localparam logic [11:0] DEC_INC_NEG  = 12'd6;
    localparam logic [11:0] DEC_INC_POS  = 12'd10;

    // one iteration, latched at input transfer and walked pixel by pixel
    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [15:0] color;
        logic        done;
        logic        idle;
    } job_t;

    // how one mirrored pixel is formed from the two offsets
    typedef struct packed {
        logic x_use_b;
        logic x_neg;
        logic y_neg;
    } pix_sel_t;

    function automatic pix_sel_t pixel_sel(input logic [2:0] k);
        pix_sel_t s;
        unique case (k)
            3'd0:    s = '{x_use_b: 1'b0, x_neg: 1'b0, y_neg: 1'b1};
            3'd1:    s = '{x_use_b: 1'b1, x_neg: 1'b0, y_neg: 1'b1};
            3'd2:    s = '{x_use_b: 1'b1, x_neg: 1'b0, y_neg: 1'b0};
            3'd3:    s = '{x_use_b: 1'b0, x_neg: 1'b0, y_neg: 1'b0};
            3'd4:    s = '{x_use_b: 1'b0, x_neg: 1'b1, y_neg: 1'b0};
            3'd5:    s = '{x_use_b: 1'b1, x_neg: 1'b1, y_neg: 1'b0};
            3'd6:    s = '{x_use_b: 1'b0, x_neg: 1'b1, y_neg: 1'b1};
            default: s = '{x_use_b: 1'b1, x_neg: 1'b1, y_neg: 1'b1};
        endcase
        return s;
    endfunction

endpackage

// ===== src/circle_outline_pixel_generator.sv =====
// circle outline pixel generator: one midpoint iteration per input transfer, eight pixels out
// an item's first result passes through the job register and then the output register
// an iteration item gives eight pixels, one pixel per cycle from the pixel walker while out_stall does not hold it;
//   a step item with no circle in progress gives a single result; next item taken as the last pixel leaves
// reset (rst_n, async, active low): no circle in progress, limits back to 320 x 240
// depends on copg_pkg and circle_outline_pixel_generator_macros.svh
`include "circle_outline_pixel_generator_macros.svh"

module circle_outline_pixel_generator (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [15:0] center_x,
    input  logic [15:0] center_y,
    input  logic [7:0]  radius,
    input  logic [15:0] color,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] pixel_x,
    output logic [15:0] pixel_y,
    output logic [15:0] pixel_color,
    output logic        visible,
    output logic        last_of_step,
    output logic        circle_done
);

    // configuration
    logic [15:0] x_limit_reg;
    logic [15:0] y_limit_reg;

    // circle state
    logic [15:0] center_x_reg, center_x_next;
    logic [15:0] center_y_reg, center_y_next;
    logic [7:0]  offset_a_reg, offset_a_next;
    logic [7:0]  offset_b_reg, offset_b_next;
    logic [11:0] decision_reg, decision_next;
    logic [15:0] color_reg,    color_next;
    logic        active_reg,   active_next;

    // iteration held for the pixel walker
    copg_pkg::job_t job_reg, job_next;
    logic           job_valid_reg, job_valid_next;
    logic [2:0]     pix_idx_reg, pix_idx_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [15:0] pixel_x_reg, pixel_x_next;
    logic [15:0] pixel_y_reg, pixel_y_next;
    logic [15:0] pixel_color_reg, pixel_color_next;
    logic        visible_reg, visible_next;
    logic        last_reg, last_next;
    logic        done_reg, done_next;

    // iteration datapath
    logic        in_xfer;
    logic        start;
    logic        idle_step;
    logic [15:0] cur_cx, cur_cy, cur_color;
    logic [7:0]  cur_a, cur_b;
    logic [11:0] cur_d;
    logic [8:0]  a_inc;
    logic [11:0] a_inc_x4;
    logic [9:0]  b_new;
    logic [11:0] d_new;
    logic        it_done;

    // pixel walker
    logic                 out_ready;
    logic                 emit;
    logic                 job_last;
    copg_pkg::pix_sel_t   sel;
    logic [15:0]          off_x, off_y;
    logic [15:0]          px, py;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= copg_pkg::X_LIMIT_RESET;
            y_limit_reg <= copg_pkg::Y_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                copg_pkg::CFG_X_LIMIT: x_limit_reg <= cfg_data;
                copg_pkg::CFG_Y_LIMIT: y_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_ready = !out_valid_reg || !out_stall;
    assign job_last  = job_reg.idle || (pix_idx_reg == 3'd7);
    assign emit      = job_valid_reg && out_ready;
    assign in_stall  = job_valid_reg && !(out_ready && job_last);
    assign in_xfer   = in_valid && !in_stall;

    // ---------------- one midpoint iteration ----------------
    always_comb
    begin
        start     = (op == copg_pkg::OP_START);
        idle_step = !start && !active_reg;

        cur_cx    = start ? center_x : center_x_reg;
        cur_cy    = start ? center_y : center_y_reg;
        cur_color = start ? color    : color_reg;
        cur_a     = start ? 8'd0     : offset_a_reg;
        cur_b     = start ? radius   : offset_b_reg;
        cur_d     = start ? (copg_pkg::DEC_INIT - {3'b000, radius, 1'b0}) : decision_reg;

        // a advances first and the new a feeds the update
        a_inc    = {1'b0, cur_a} + 9'd1;
        a_inc_x4 = {1'b0, a_inc, 2'b00};
        if (cur_d[11])
        begin
            d_new = cur_d + a_inc_x4 + copg_pkg::DEC_INC_NEG;
            b_new = {2'b00, cur_b};
        end
        else
        begin
            d_new = cur_d + copg_pkg::DEC_INC_POS + a_inc_x4 - {2'b00, cur_b, 2'b00};
            b_new = {2'b00, cur_b} - 10'd1;
        end
        // signed compare so a b that goes below zero also ends the circle
        it_done = $signed({1'b0, a_inc}) > $signed(b_new);
    end

    always_comb
    begin
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        color_next    = color_reg;
        offset_a_next = offset_a_reg;
        offset_b_next = offset_b_reg;
        decision_next = decision_reg;
        active_next   = active_reg;
        if (in_xfer && !idle_step)
        begin
            center_x_next = cur_cx;
            center_y_next = cur_cy;
            color_next    = cur_color;
            offset_a_next = a_inc[7:0];
            offset_b_next = b_new[7:0];
            decision_next = d_new;
            active_next   = !it_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            color_reg    <= '0;
            offset_a_reg <= '0;
            offset_b_reg <= '0;
            decision_reg <= '0;
            active_reg   <= 1'b0;
        end
        else
        begin
            center_x_reg <= center_x_next;
            center_y_reg <= center_y_next;
            color_reg    <= color_next;
            offset_a_reg <= offset_a_next;
            offset_b_reg <= offset_b_next;
            decision_reg <= decision_next;
            active_reg   <= active_next;
        end
    end

    // ---------------- job register and pixel walker ----------------
    always_comb
    begin
        job_next       = job_reg;
        job_valid_next = job_valid_reg;
        pix_idx_next   = pix_idx_reg;
        if (emit)
        begin
            pix_idx_next = pix_idx_reg + 3'd1;
            if (job_last)
            begin
                job_valid_next = 1'b0;
                pix_idx_next   = 3'd0;
            end
        end
        if (in_xfer)
        begin
            job_next.cx    = cur_cx;
            job_next.cy    = cur_cy;
            job_next.a     = cur_a;
            job_next.b     = cur_b;
            job_next.color = cur_color;
            job_next.done  = it_done;
            job_next.idle  = idle_step;
            job_valid_next = 1'b1;
            pix_idx_next   = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            pix_idx_reg   <= 3'd0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            pix_idx_reg   <= pix_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    // mirrored pixel for the current index
    always_comb
    begin
        sel   = copg_pkg::pixel_sel(pix_idx_reg);
        off_x = {8'h00, (sel.x_use_b ? job_reg.b : job_reg.a)};
        off_y = {8'h00, (sel.x_use_b ? job_reg.a : job_reg.b)};
        px    = sel.x_neg ? (job_reg.cx - off_x) : (job_reg.cx + off_x);
        py    = sel.y_neg ? (job_reg.cy - off_y) : (job_reg.cy + off_y);
    end

    // ---------------- output register ----------------
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        pixel_x_next     = pixel_x_reg;
        pixel_y_next     = pixel_y_reg;
        pixel_color_next = pixel_color_reg;
        visible_next     = visible_reg;
        last_next        = last_reg;
        done_next        = done_reg;
        if (out_ready)
        begin
            out_valid_next = job_valid_reg;
            if (job_reg.idle)
            begin
                // step with no circle in progress
                pixel_x_next     = 16'd0;
                pixel_y_next     = 16'd0;
                pixel_color_next = 16'd0;
                visible_next     = 1'b0;
                last_next        = 1'b1;
                done_next        = 1'b1;
            end
            else
            begin
                pixel_x_next     = px;
                pixel_y_next     = py;
                pixel_color_next = job_reg.color;
                visible_next     = (px <= x_limit_reg) && (py <= y_limit_reg);
                last_next        = (pix_idx_reg == 3'd7);
                done_next        = job_reg.done;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_x_reg     <= pixel_x_next;
        pixel_y_reg     <= pixel_y_next;
        pixel_color_reg <= pixel_color_next;
        visible_reg     <= visible_next;
        last_reg        <= last_next;
        done_reg        <= done_next;
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign pixel_color  = pixel_color_reg;
    assign visible      = visible_reg;
    assign last_of_step = last_reg;
    assign circle_done  = done_reg;

    // ---------------- assertions ----------------
    // walker index only moves while an iteration is held
    `COPG_ASSERT_SAME(a_idx_needs_job, clk, rst_n, (pix_idx_reg != 3'd0), job_valid_reg)
    // an idle step is a single result
    `COPG_ASSERT_SAME(a_idle_single, clk, rst_n, (job_valid_reg && job_reg.idle),
        (pix_idx_reg == 3'd0))
    // a held iteration that completes the circle leaves no circle in progress
    `COPG_ASSERT_SAME(a_done_clears_active, clk, rst_n,
        (job_valid_reg && !job_reg.idle && job_reg.done), !active_reg)
    // a new item only enters as the held iteration hands over its last pixel
    `COPG_ASSERT_NEXT(a_no_overrun, clk, rst_n, (in_xfer && job_valid_reg && !job_reg.idle),
        (out_valid_reg && last_reg))

endmodule
